// ===== design/apmtsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apmtsb_pkg
// Types and constants shared by the PM event block: item layouts, action
// codes, register offsets and status/control bit positions.
// ----------------------------------------------------------------------------
package apmtsb_pkg;

	// Action carried by one request item
	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_READ   = 2'd1,
		ACT_WRITE  = 2'd2,
		ACT_PWRBTN = 2'd3
	} action_t;

	// Register byte offsets
	localparam logic [5:0] OFS_STATUS  = 6'h00;
	localparam logic [5:0] OFS_ENABLE  = 6'h02;
	localparam logic [5:0] OFS_CONTROL = 6'h04;
	localparam logic [5:0] OFS_TIMER   = 6'h08;

	// Status and enable bits
	localparam logic [15:0] ST_RESUME  = 16'h8000;
	localparam logic [15:0] BIT_RTC    = 16'h0400;
	localparam logic [15:0] BIT_PWRBTN = 16'h0100;
	localparam logic [15:0] BIT_GBL    = 16'h0020;
	localparam logic [15:0] BIT_TMROF  = 16'h0001;
	localparam logic [15:0] SCI_MASK   = BIT_RTC | BIT_PWRBTN | BIT_GBL | BIT_TMROF;

	// Control register: suspend enable and suspend type field
	localparam int          CTL_SUS_EN_BIT = 13;
	localparam logic [15:0] CTL_SUS_EN     = 16'h2000;
	localparam int          CTL_TYP_LSB    = 10;
	localparam logic [2:0]  SUS_TYP_OFF    = 3'd0;
	localparam logic [2:0]  SUS_TYP_RESET  = 3'd1;

	// Counter geometry: overflow due count is kept as a multiple of 2^23
	localparam int TICK_W     = 64;
	localparam int OVF_SHIFT  = 23;
	localparam int DUE_W      = TICK_W - OVF_SHIFT;
	localparam int TIMER_READ_BITS = 24;
	localparam int READ_W     = 24;

	typedef struct packed {
		action_t     action;
		logic [5:0]  offset;
		logic [15:0] write_data;
	} req_t;

	typedef struct packed {
		logic [READ_W-1:0] read_data;
		logic              sci;
		logic              shutdown_request;
		logic              reset_request;
	} rsp_t;

endpackage

// ===== design/apmtsb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apmtsb_core
// Architectural state of the PM event block (status, enable, control, tick
// counter, overflow due count) and the next-state logic for one item.
// ----------------------------------------------------------------------------
module apmtsb_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  apmtsb_pkg::req_t  req,
	output apmtsb_pkg::rsp_t  rsp
);

	logic [15:0]                    status_q;
	logic [15:0]                    enable_q;
	logic [15:0]                    control_q;
	logic [apmtsb_pkg::TICK_W-1:0]  tick_q;
	logic [apmtsb_pkg::DUE_W-1:0]   due_q;

	logic [15:0]                    status_nx;
	logic [15:0]                    status_pre;
	logic [15:0]                    enable_nx;
	logic [15:0]                    control_nx;
	logic [apmtsb_pkg::TICK_W-1:0]  tick_nx;
	logic [apmtsb_pkg::DUE_W-1:0]   due_nx;
	logic [apmtsb_pkg::DUE_W-1:0]   tick_hi;
	logic                           due_hit;
	logic                           tmrof_late;
	logic [apmtsb_pkg::TIMER_READ_BITS-1:0] timer_low;
	logic [2:0]                     sus_typ;

	// Advance the counter and compare against the due count
	assign tick_nx   = (req.action == apmtsb_pkg::ACT_TICK) ? tick_q + 64'd1 : tick_q;
	assign tick_hi   = tick_nx[apmtsb_pkg::TICK_W-1:apmtsb_pkg::OVF_SHIFT];
	assign due_hit   = (tick_hi >= due_q);
	assign status_pre = status_q | (due_hit ? apmtsb_pkg::BIT_TMROF : 16'h0000);
	assign timer_low = tick_nx[apmtsb_pkg::TIMER_READ_BITS-1:0];
	assign sus_typ   = req.write_data[apmtsb_pkg::CTL_TYP_LSB +: 3];

	// Decode the item and form next state and result
	always_comb begin
		status_nx            = status_pre;
		enable_nx            = enable_q;
		control_nx           = control_q;
		due_nx               = due_q;
		tmrof_late           = due_hit;
		rsp.read_data        = '0;
		rsp.shutdown_request = 1'b0;
		rsp.reset_request    = 1'b0;
		case (req.action)
			apmtsb_pkg::ACT_READ: begin
				case (req.offset)
					apmtsb_pkg::OFS_STATUS:  rsp.read_data = {8'h00, status_pre};
					apmtsb_pkg::OFS_ENABLE:  rsp.read_data = {8'h00, enable_q};
					apmtsb_pkg::OFS_CONTROL: rsp.read_data = {8'h00, control_q};
					apmtsb_pkg::OFS_TIMER:   rsp.read_data = apmtsb_pkg::READ_W'(timer_low);
					default:                 rsp.read_data = '0;
				endcase
			end
			apmtsb_pkg::ACT_WRITE: begin
				case (req.offset)
					apmtsb_pkg::OFS_STATUS: begin
						// clearing the overflow moves the due count to the next 2^23 step
						if (status_pre[0] && req.write_data[0]) begin
							due_nx     = tick_hi + apmtsb_pkg::DUE_W'(1);
							tmrof_late = &tick_hi;
						end
						status_nx = status_pre & ~req.write_data;
					end
					apmtsb_pkg::OFS_ENABLE: enable_nx = req.write_data;
					apmtsb_pkg::OFS_CONTROL: begin
						control_nx = req.write_data & ~apmtsb_pkg::CTL_SUS_EN;
						if (req.write_data[apmtsb_pkg::CTL_SUS_EN_BIT]) begin
							if (sus_typ == apmtsb_pkg::SUS_TYP_OFF) begin
								rsp.shutdown_request = 1'b1;
							end else if (sus_typ == apmtsb_pkg::SUS_TYP_RESET) begin
								status_nx = status_pre | apmtsb_pkg::ST_RESUME
									| apmtsb_pkg::BIT_PWRBTN;
								rsp.reset_request = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			apmtsb_pkg::ACT_PWRBTN: begin
				if ((enable_q & apmtsb_pkg::BIT_PWRBTN) != 16'h0000) begin
					status_nx = status_pre | apmtsb_pkg::BIT_PWRBTN;
				end
			end
			default: ;
		endcase
		// second overflow check before the interrupt is formed
		if (tmrof_late) begin
			status_nx = status_nx | apmtsb_pkg::BIT_TMROF;
		end
		rsp.sci = |(status_nx & enable_nx & apmtsb_pkg::SCI_MASK);
	end

	// Hold state; update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			enable_q  <= '0;
			control_q <= '0;
			tick_q    <= '0;
			due_q     <= '0;
		end else if (step) begin
			status_q  <= status_nx;
			enable_q  <= enable_nx;
			control_q <= control_nx;
			tick_q    <= tick_nx;
			due_q     <= due_nx;
		end
	end

	// A tick item advances the counter by exactly one
	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		step && req.action == apmtsb_pkg::ACT_TICK |=> tick_q == $past(tick_q) + 64'd1)
		else $error("tick item did not advance counter");

	// Once an item is done, a reached due count always shows as overflow status
	a_ovf_seen: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> status_q[0] ||
			(tick_q[apmtsb_pkg::TICK_W-1:apmtsb_pkg::OVF_SHIFT] < due_q))
		else $error("overflow due but status bit clear");

	// Shutdown and reset are never requested by the same item
	a_req_excl: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(rsp.shutdown_request && rsp.reset_request))
		else $error("shutdown and reset requested together");

endmodule

// ===== design/acpi_pm_timer_status_block_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpi_pm_timer_status_block_top
// PM1 event block with PM timer: tick, bus read/write and power-button items
// update the registers; each item yields one result item.
// ----------------------------------------------------------------------------
// A result becomes valid in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the state update is one pass of logic.
// req_ready stays high while the result register is empty or being drained.
// Reset clears status, enable, control, tick counter and due count, and
// empties the result register.
module acpi_pm_timer_status_block_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  apmtsb_pkg::req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output apmtsb_pkg::rsp_t  rsp
);

	logic              step;
	logic              rsp_valid_q;
	apmtsb_pkg::rsp_t  rsp_q;
	apmtsb_pkg::rsp_t  rsp_nx;

	// Accept a new item whenever the result register frees up this cycle
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign step      = req_valid && req_ready;

	apmtsb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req),
		.rsp    (rsp_nx)
	);

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_ready) begin
			rsp_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
